### rtl/core/c3ac_pkg.sv
// c3ac_pkg: shared widths, register indexes, reset coefficients and the
// result bundle type of the 3x3 convolution block.
// No dependencies.
`default_nettype none

package c3ac_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned COEF_W     = 16;
  localparam int unsigned COEF_ROW_W = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned KSIZE      = 3;
  localparam int unsigned NUM_SLOTS  = 3;

  // product of an 8-bit sample (made signed) and a Q8.8 coefficient
  localparam int unsigned PROD_W = SAMPLE_W + 1 + COEF_W;
  localparam int unsigned PSUM_W = PROD_W + 2;
  localparam int unsigned SUM_W  = PSUM_W + 2;

  localparam int unsigned SIZE_RST = 1024;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MIDDLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOTTOM  = 3'd4;

  // 1-2-1 Gaussian in Q8.8, left coefficient in the low bits
  localparam logic [COEF_ROW_W-1:0] COEF_OUTER_RST = 48'h0010_0020_0010;
  localparam logic [COEF_ROW_W-1:0] COEF_INNER_RST = 48'h0020_0040_0020;

  localparam logic [SAMPLE_W-1:0] PIX_MAX = 8'hFF;

  // slot 0: (row_prev, col_prev), slot 1: (row_prev, col_cur),
  // slot 2: (row_cur, col_cur)
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic                 frame_last;
    logic [COORD_W-1:0]   row_prev;
    logic [COORD_W-1:0]   row_cur;
    logic [COORD_W-1:0]   col_prev;
    logic [COORD_W-1:0]   col_cur;
    logic [SAMPLE_W-1:0]  px0;
    logic [SAMPLE_W-1:0]  px1;
    logic [SAMPLE_W-1:0]  px2;
  } bundle_t;

endpackage

`default_nettype wire

### rtl/core/c3ac_in_if.sv
// c3ac_in_if: sample input channel (valid/ready, one gray sample).
// Depends on c3ac_pkg.
`default_nettype none

interface c3ac_in_if;
  logic                          valid;
  logic                          ready;
  logic [c3ac_pkg::SAMPLE_W-1:0] gray_sample;

  modport source (output valid, output gray_sample, input ready);
  modport sink   (input valid, input gray_sample, output ready);
endinterface

`default_nettype wire

### rtl/core/c3ac_out_if.sv
// c3ac_out_if: result channel (valid/ready, coordinates, pixel, flags).
// Depends on c3ac_pkg.
`default_nettype none

interface c3ac_out_if;
  logic                          valid;
  logic                          ready;
  logic [c3ac_pkg::COORD_W-1:0]  out_row;
  logic [c3ac_pkg::COORD_W-1:0]  out_col;
  logic [c3ac_pkg::SAMPLE_W-1:0] out_pixel;
  logic                          last_of_run;
  logic                          frame_done;

  modport source (output valid, output out_row, output out_col, output out_pixel,
                  output last_of_run, output frame_done, input ready);
  modport sink   (input valid, input out_row, input out_col, input out_pixel,
                  input last_of_run, input frame_done, output ready);
endinterface

`default_nettype wire

### rtl/core/c3ac_cfg_if.sv
// c3ac_cfg_if: configuration write channel (valid/ready, index, data).
// Depends on c3ac_pkg.
`default_nettype none

interface c3ac_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [c3ac_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [c3ac_pkg::COEF_ROW_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

### rtl/core/c3ac_ram.sv
// c3ac_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`default_nettype none

module c3ac_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/c3ac_outq.sv
// c3ac_outq: queue of per-sample result bundles; hands out up to three
// results per bundle, one transaction at a time. Depends on c3ac_pkg, c3ac_out_if.
`default_nettype none

module c3ac_outq #(
  parameter int unsigned DEPTH = 8,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire c3ac_pkg::bundle_t push_data,
  output logic [CW-1:0]          count,
  c3ac_out_if.source             out_ch
);

  localparam int unsigned NS = c3ac_pkg::NUM_SLOTS;

  c3ac_pkg::bundle_t q_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic [NS-1:0]     done_r;

  c3ac_pkg::bundle_t head;
  logic [NS-1:0]     pend;
  logic [NS-1:0]     sel_bit;
  logic [NS-1:0]     rest;
  logic [1:0]        sel;
  logic              last;
  logic              fire;
  logic              pop;

  assign head = q_r[rd_ptr_r];
  assign pend = head.mask & ~done_r;

  // lowest pending slot goes first
  always_comb begin
    if (pend[0]) begin
      sel = 2'd0;
    end else if (pend[1]) begin
      sel = 2'd1;
    end else begin
      sel = 2'd2;
    end
    sel_bit = NS'(1) << sel;
    rest    = pend & ~sel_bit;
    last    = (rest == '0);
  end

  always_comb begin
    case (sel)
      2'd0: begin
        out_ch.out_row   = head.row_prev;
        out_ch.out_col   = head.col_prev;
        out_ch.out_pixel = head.px0;
      end
      2'd1: begin
        out_ch.out_row   = head.row_prev;
        out_ch.out_col   = head.col_cur;
        out_ch.out_pixel = head.px1;
      end
      default: begin
        out_ch.out_row   = head.row_cur;
        out_ch.out_col   = head.col_cur;
        out_ch.out_pixel = head.px2;
      end
    endcase
  end

  assign out_ch.valid       = (count_r != '0);
  assign out_ch.last_of_run = last;
  assign out_ch.frame_done  = last & head.frame_last;
  assign count              = count_r;

  assign fire = out_ch.valid & out_ch.ready;
  assign pop  = fire & last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      done_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (fire) begin
        if (last) begin
          done_r   <= '0;
          rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
        end else begin
          done_r <= done_r | sel_bit;
        end
      end
      count_r <= count_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r < CW'(DEPTH)))
    else $error("outq: push into full queue");

  a_head_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (pend != '0))
    else $error("outq: head bundle has no pending result");

  a_done_in_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ((done_r & ~head.mask) == '0))
    else $error("outq: sent slot outside bundle mask");

endmodule

`default_nettype wire

### rtl/core/convolution_3x3_abs_clamp_top.sv
// convolution_3x3_abs_clamp_top: streaming 3x3 convolution with absolute value
// and clamp. Depends on c3ac_pkg, c3ac_*_if, c3ac_ram, c3ac_outq.
//
//   channel | dir | payload                                        | accepted when
//   --------+-----+------------------------------------------------+---------------------
//   in_ch   | in  | gray_sample[7:0]                               | valid & ready
//   out_ch  | out | out_row[9:0] out_col[9:0] out_pixel[7:0] flags | valid & ready
//   cfg_ch  | in  | reg_index[2:0] wdata[47:0]                     | valid & ready (always)
//
// One sample per cycle while in_ch.ready is high; results leave one per cycle while
// out_ch.ready is high, 0 to 3 per sample, and reach the queue from stage 5.
// in_ch.ready drops only when queued bundles plus transactions in the 5 pipeline stages
// reach the 8-bundle queue depth, i.e. when out_ch stalls or 2-3 result bursts pile up.
// Reset (rst_n low, synchronous) restores 1024x1024 and the 1-2-1 Gaussian
// kernel and zeroes row/col; line store contents are not cleared.
`default_nettype none

module convolution_3x3_abs_clamp_top #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input wire logic   clk,
  input wire logic   rst_n,
  c3ac_in_if.sink    in_ch,
  c3ac_out_if.source out_ch,
  c3ac_cfg_if.sink   cfg_ch
);

  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned YW     = $clog2(MAX_HEIGHT);
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);
  localparam int unsigned ACW    = QCW + 1;
  localparam int unsigned K      = c3ac_pkg::KSIZE;
  localparam int unsigned SW     = c3ac_pkg::SAMPLE_W;
  localparam int unsigned CRW    = c3ac_pkg::COORD_W;
  localparam int unsigned CFW    = c3ac_pkg::COEF_W;
  localparam int unsigned PRW    = c3ac_pkg::PROD_W;
  localparam int unsigned PSW    = c3ac_pkg::PSUM_W;
  localparam int unsigned SUW    = c3ac_pkg::SUM_W;

  localparam logic [XW-1:0] W_RST_LAST = XW'(((c3ac_pkg::SIZE_RST > MAX_WIDTH) ?
                                               MAX_WIDTH : c3ac_pkg::SIZE_RST) - 1);
  localparam logic [YW-1:0] H_RST_LAST = YW'(((c3ac_pkg::SIZE_RST > MAX_HEIGHT) ?
                                               MAX_HEIGHT : c3ac_pkg::SIZE_RST) - 1);

  // per-sample control that rides down the pipeline
  typedef struct packed {
    logic [c3ac_pkg::NUM_SLOTS-1:0] mask;
    logic                           filt;
    logic                           frame_last;
    logic [CRW-1:0]                 row_prev;
    logic [CRW-1:0]                 row_cur;
    logic [CRW-1:0]                 col_prev;
    logic [CRW-1:0]                 col_cur;
  } item_t;

  // ---------------- configuration ----------------
  logic [XW-1:0]                       w_last_r;
  logic [YW-1:0]                       h_last_r;
  logic [c3ac_pkg::COEF_ROW_W-1:0]     coef_r [K];
  logic [c3ac_pkg::SIZE_W-1:0]         cfg_size;
  logic [XW-1:0]                       cfg_w_last;
  logic [YW-1:0]                       cfg_h_last;
  logic                                cfg_fire;
  logic                                size_wr;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid & cfg_ch.ready;
  assign cfg_size     = cfg_ch.wdata[c3ac_pkg::SIZE_W-1:0];
  assign size_wr      = cfg_fire && (cfg_ch.reg_index == c3ac_pkg::REG_IMAGE_WIDTH ||
                                     cfg_ch.reg_index == c3ac_pkg::REG_IMAGE_HEIGHT);

  // sizes are clamped to [3, MAX] and kept as last index
  always_comb begin
    if (cfg_size < 3) begin
      cfg_w_last = XW'(2);
      cfg_h_last = YW'(2);
    end else begin
      cfg_w_last = (cfg_size > MAX_WIDTH)  ? XW'(MAX_WIDTH - 1)
                                           : XW'(cfg_size - 11'd1);
      cfg_h_last = (cfg_size > MAX_HEIGHT) ? YW'(MAX_HEIGHT - 1)
                                           : YW'(cfg_size - 11'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r  <= W_RST_LAST;
      h_last_r  <= H_RST_LAST;
      coef_r[0] <= c3ac_pkg::COEF_OUTER_RST;
      coef_r[1] <= c3ac_pkg::COEF_INNER_RST;
      coef_r[2] <= c3ac_pkg::COEF_OUTER_RST;
    end else if (cfg_fire) begin
      unique case (cfg_ch.reg_index)
        c3ac_pkg::REG_IMAGE_WIDTH:  w_last_r  <= cfg_w_last;
        c3ac_pkg::REG_IMAGE_HEIGHT: h_last_r  <= cfg_h_last;
        c3ac_pkg::REG_COEF_TOP:     coef_r[0] <= cfg_ch.wdata;
        c3ac_pkg::REG_COEF_MIDDLE:  coef_r[1] <= cfg_ch.wdata;
        c3ac_pkg::REG_COEF_BOTTOM:  coef_r[2] <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // ---------------- raster position, admission ----------------
  logic [XW-1:0]  col_r;
  logic [YW-1:0]  row_r;
  logic           in_fire;
  logic           col_end;
  logic           row_end;
  item_t          acc_item;

  logic           s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r;
  logic [QCW-1:0] q_count;
  logic [ACW-1:0] in_use;

  // every in-flight transaction holds one queue slot until it leaves stage 5
  assign in_use = ACW'(q_count) + ACW'(s1_v_r) + ACW'(s2_v_r) + ACW'(s3_v_r)
                + ACW'(s4_v_r) + ACW'(s5_v_r);
  assign in_ch.ready = (in_use < ACW'(QDEPTH));
  assign in_fire     = in_ch.valid & in_ch.ready;

  assign col_end = (col_r == w_last_r);
  assign row_end = (row_r == h_last_r);

  // which results this sample produces and their coordinates
  always_comb begin
    acc_item.mask[0]    = (row_r != '0) && (col_r != '0);
    acc_item.mask[1]    = (row_r != '0) && col_end;
    acc_item.mask[2]    = row_end;
    acc_item.filt       = (row_r >= YW'(2)) && (col_r >= XW'(2));
    acc_item.frame_last = row_end && col_end;
    acc_item.row_prev   = CRW'(row_r - YW'(1));
    acc_item.row_cur    = CRW'(row_r);
    acc_item.col_prev   = CRW'(col_r - XW'(1));
    acc_item.col_cur    = CRW'(col_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (size_wr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_fire) begin
      if (col_end) begin
        col_r <= '0;
        row_r <= row_end ? '0 : row_r + YW'(1);
      end else begin
        col_r <= col_r + XW'(1);
      end
    end
  end

  // ---------------- line stores ----------------
  // one RAM, {older, newer} per column; read on the transaction,
  // written back in the next cycle. Consecutive samples never share a column.
  logic [2*SW-1:0] ram_rdata;
  logic [SW-1:0]   s1_sample_r;
  logic [XW-1:0]   s1_col_r;
  item_t           s1_item_r;

  c3ac_ram #(
    .WIDTH (2 * SW),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .we      (s1_v_r),
    .waddr   (s1_col_r),
    .wdata   ({ram_rdata[SW-1:0], s1_sample_r}),
    .re      (in_fire),
    .raddr   (col_r),
    .rdata_r (ram_rdata)
  );

  // ---------------- window (stage 1 updates it) ----------------
  logic [SW-1:0] win_r [K][K];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int kr = 0; kr < K; kr++) begin
        for (int kc = 0; kc < K; kc++) begin
          win_r[kr][kc] <= '0;
        end
      end
    end else if (s1_v_r) begin
      for (int kr = 0; kr < K; kr++) begin
        for (int kc = 0; kc < K - 1; kc++) begin
          win_r[kr][kc] <= win_r[kr][kc+1];
        end
      end
      win_r[0][K-1] <= ram_rdata[2*SW-1:SW];
      win_r[1][K-1] <= ram_rdata[SW-1:0];
      win_r[2][K-1] <= s1_sample_r;
    end
  end

  // ---------------- arithmetic pipeline ----------------
  item_t                s2_item_r, s3_item_r, s4_item_r, s5_item_r;
  logic [SW-1:0]        s3_px_r [c3ac_pkg::NUM_SLOTS];
  logic [SW-1:0]        s4_px_r [c3ac_pkg::NUM_SLOTS];
  logic [SW-1:0]        s5_px_r [c3ac_pkg::NUM_SLOTS];
  logic signed [PRW-1:0] prod_nxt [K][K];
  logic signed [PRW-1:0] prod_r   [K][K];
  logic signed [PSW-1:0] psum_r   [K];
  logic signed [SUW-1:0] sum_r;

  always_comb begin
    for (int kr = 0; kr < K; kr++) begin
      for (int kc = 0; kc < K; kc++) begin
        prod_nxt[kr][kc] = $signed({1'b0, win_r[kr][kc]}) *
                           $signed(coef_r[kr][CFW*kc +: CFW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_fire;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_ch.gray_sample;
      s1_col_r    <= col_r;
      s1_item_r   <= acc_item;
    end
    s2_item_r <= s1_item_r;
    // stage 2 sees the updated window: center, right of center, new sample
    s3_item_r  <= s2_item_r;
    s3_px_r[0] <= win_r[1][1];
    s3_px_r[1] <= win_r[1][2];
    s3_px_r[2] <= win_r[2][2];
    prod_r     <= prod_nxt;
    s4_item_r <= s3_item_r;
    s4_px_r   <= s3_px_r;
    for (int kr = 0; kr < K; kr++) begin
      psum_r[kr] <= PSW'(prod_r[kr][0]) + PSW'(prod_r[kr][1]) + PSW'(prod_r[kr][2]);
    end
    s5_item_r <= s4_item_r;
    s5_px_r   <= s4_px_r;
    sum_r     <= SUW'(psum_r[0]) + SUW'(psum_r[1]) + SUW'(psum_r[2]);
  end

  // magnitude, truncated toward zero, clamped to 255
  logic [SUW-1:0]  mag;
  logic [SW-1:0]   filt_px;
  logic            push;
  c3ac_pkg::bundle_t push_data;

  always_comb begin
    mag     = sum_r[SUW-1] ? SUW'(-sum_r) : SUW'(sum_r);
    filt_px = (mag[SUW-1:SW+8] != '0) ? c3ac_pkg::PIX_MAX : mag[SW+7:8];
  end

  assign push = s5_v_r && (s5_item_r.mask != '0);

  always_comb begin
    push_data.mask       = s5_item_r.mask;
    push_data.frame_last = s5_item_r.frame_last;
    push_data.row_prev   = s5_item_r.row_prev;
    push_data.row_cur    = s5_item_r.row_cur;
    push_data.col_prev   = s5_item_r.col_prev;
    push_data.col_cur    = s5_item_r.col_cur;
    push_data.px0        = s5_item_r.filt ? filt_px : s5_px_r[0];
    push_data.px1        = s5_px_r[1];
    push_data.px2        = s5_px_r[2];
  end

  c3ac_outq #(
    .DEPTH (QDEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .count     (q_count),
    .out_ch    (out_ch)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_use <= ACW'(QDEPTH))
    else $error("top: more transactions in flight than queue slots");

  a_filt_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_item_r.filt) |-> s1_item_r.mask[0])
    else $error("top: filtered pixel without a result slot");

endmodule

`default_nettype wire

### test/testbench.sv
// testbench: self-checking bench for convolution_3x3_abs_clamp_top. Streams gray
// samples over frames of many sizes and kernels and checks every result transaction.
// Depends on c3ac_pkg, c3ac_in_if, c3ac_out_if, c3ac_cfg_if and the block's RTL.
module testbench;
  import c3ac_pkg::*;

  localparam int unsigned MAX_W          = 1024;
  localparam int unsigned MAX_H          = 1024;
  localparam int unsigned HALF_PERIOD    = 4;
  localparam int unsigned RESET_CYCLES   = 11;
  localparam int unsigned DRAIN_CYCLES   = 16;     // 5-stage pipe plus margin
  localparam int unsigned HOLD_CYCLES    = 400;    // long output stall
  localparam int unsigned RANDOM_ITEMS   = 380;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam longint      TIMEOUT_CYCLES = 1_500_000;

  // one result transaction as seen on out_ch
  typedef struct packed {
    logic [COORD_W-1:0]  row;
    logic [COORD_W-1:0]  col;
    logic [SAMPLE_W-1:0] pixel;
    logic                last;
    logic                done;
  } pixel_result_t;

  logic clk;
  logic rst_n;

  c3ac_in_if  in_ch ();
  c3ac_out_if out_ch ();
  c3ac_cfg_if cfg_ch ();

  convolution_3x3_abs_clamp_top #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // --------------------------------------------------------------------------
  // Shadow copy of the block: registers, line stores, window, raster position
  // --------------------------------------------------------------------------
  logic [SIZE_W-1:0]     width_reg;
  logic [SIZE_W-1:0]     height_reg;
  logic [COEF_ROW_W-1:0] coef_rows [KSIZE];
  logic [SAMPLE_W-1:0]   older_line [MAX_W];
  logic [SAMPLE_W-1:0]   newer_line [MAX_W];
  logic [SAMPLE_W-1:0]   win [KSIZE][KSIZE];
  int unsigned           row_pos;
  int unsigned           col_pos;

  logic [SAMPLE_W-1:0] samples_to_send [$];   // fed to the input driver
  pixel_result_t       expected_pixels [$];   // predicted results, oldest first

  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 68;
  int unsigned samples_accepted = 0;
  int unsigned results_checked  = 0;
  int unsigned reg_writes       = 0;
  int unsigned error_count      = 0;
  int unsigned pressure_start   = 0;          // 0 = no stall requested yet
  logic        hold_off;

  // Clock: period 8
  initial clk = 1'b0;
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: advance the shadow state by one sample and queue the 0..3
  // results it releases. Interior pixels are filtered, border pixels pass.
  // --------------------------------------------------------------------------
  task automatic convolve_sample(input logic [SAMPLE_W-1:0] s);
    int unsigned         w, h, r, c, n, kr, kc;
    logic [SAMPLE_W-1:0] above2, above1, px;
    logic [COEF_W-1:0]   cbits;
    longint              acc, mag;
    pixel_result_t       batch [NUM_SLOTS];

    // out-of-range sizes are used clamped
    w = (width_reg < 3) ? 3 : (width_reg > MAX_W) ? MAX_W : width_reg;
    h = (height_reg < 3) ? 3 : (height_reg > MAX_H) ? MAX_H : height_reg;
    r = row_pos;
    c = col_pos;
    n = 0;
    above2 = older_line[c];
    above1 = newer_line[c];

    for (kr = 0; kr < KSIZE; kr++) begin
      win[kr][0] = win[kr][1];
      win[kr][1] = win[kr][2];
    end
    win[0][2] = above2;
    win[1][2] = above1;
    win[2][2] = s;
    older_line[c] = above1;
    newer_line[c] = s;

    // pixel (r-1, c-1): filtered if interior, else its own gray level
    if (r >= 1 && c >= 1) begin
      if (r >= 2 && c >= 2) begin
        acc = 0;
        for (kr = 0; kr < KSIZE; kr++) begin
          for (kc = 0; kc < KSIZE; kc++) begin
            cbits = coef_rows[kr][COEF_W*kc +: COEF_W];
            acc += longint'(win[kr][kc]) * longint'($signed(cbits));
          end
        end
        // magnitude then drop the Q8.8 fraction: truncation toward zero
        mag = (acc < 0) ? -acc : acc;
        mag = mag >> 8;
        px = (mag > 255) ? PIX_MAX : mag[SAMPLE_W-1:0];
      end else begin
        px = win[1][1];
      end
      batch[n] = '{row: r - 1, col: c - 1, pixel: px, last: 1'b0, done: 1'b0};
      n++;
    end
    // right border of the row above
    if (r >= 1 && c == w - 1) begin
      batch[n] = '{row: r - 1, col: c, pixel: win[1][2], last: 1'b0, done: 1'b0};
      n++;
    end
    // bottom row passes straight through
    if (r == h - 1) begin
      batch[n] = '{row: r, col: c, pixel: s, last: 1'b0, done: 1'b0};
      n++;
    end

    if (n > 0) begin
      batch[n-1].last = 1'b1;
      batch[n-1].done = (r == h - 1 && c == w - 1);
      for (kr = 0; kr < n; kr++) expected_pixels.push_back(batch[kr]);
    end

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    row_pos = r;
    col_pos = c;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: offers queued samples, idling at random. A held item keeps
  // valid high until its transaction completes.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        convolve_sample(in_ch.gray_sample);
        samples_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.valid       <= 1'b1;
          in_ch.gray_sample <= samples_to_send.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every result transaction is checked against the oldest
  // prediction; ready is withdrawn at random and during the long stall.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_monitor
    pixel_result_t got, want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_row, out_ch.out_col, out_ch.out_pixel,
               out_ch.last_of_run, out_ch.frame_done};
        results_checked++;
        if (expected_pixels.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result: row %0d col %0d pixel %0d last %0b done %0b",
                     got.row, got.col, got.pixel, got.last, got.done);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("mismatch: expected row %0d col %0d pixel %0d last %0b done %0b",
                       want.row, want.col, want.pixel, want.last, want.done);
              $display("          actual   row %0d col %0d pixel %0d last %0b done %0b",
                       got.row, got.col, got.pixel, got.last, got.done);
            end
          end
        end
      end
      out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Long receiver stall, counted here, while the sender keeps offering samples
  // so the result queue and then the input side back up.
  initial begin
    hold_off = 1'b0;
    wait (pressure_start != 0 && samples_accepted >= pressure_start);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Config writes: only issued with the block idle. Size writes restart the
  // frame; coefficient writes keep the raster position.
  // --------------------------------------------------------------------------
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [COEF_ROW_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_IMAGE_WIDTH: begin
        width_reg = value[SIZE_W-1:0];
        row_pos   = 0;
        col_pos   = 0;
      end
      REG_IMAGE_HEIGHT: begin
        height_reg = value[SIZE_W-1:0];
        row_pos    = 0;
        col_pos    = 0;
      end
      REG_COEF_TOP:    coef_rows[0] = value;
      REG_COEF_MIDDLE: coef_rows[1] = value;
      REG_COEF_BOTTOM: coef_rows[2] = value;
      default: ;
    endcase
  endtask

  // Wait until every sample went in and every predicted result came out, then
  // let the pipe settle: row 0 samples leave nothing to wait for.
  task automatic drain_results();
    do @(posedge clk);
    while (samples_to_send.size() != 0 || in_ch.valid || expected_pixels.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // gray level with extra weight on black and white
  function automatic logic [SAMPLE_W-1:0] random_gray();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return PIX_MAX;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // one kernel row: full random, small signed, saturating extremes or box
  function automatic logic [COEF_ROW_W-1:0] random_coef_row(input int unsigned kind);
    logic [COEF_ROW_W-1:0] row;
    int unsigned           k;
    for (k = 0; k < KSIZE; k++) begin
      case (kind)
        0: row[COEF_W*k +: COEF_W] = 16'($urandom);
        1: row[COEF_W*k +: COEF_W] = 16'($urandom_range(1536) - 768);
        2: begin
          case ($urandom_range(4))
            0:       row[COEF_W*k +: COEF_W] = 16'h7FFF;
            1:       row[COEF_W*k +: COEF_W] = 16'h8000;
            2:       row[COEF_W*k +: COEF_W] = 16'h0000;
            3:       row[COEF_W*k +: COEF_W] = 16'h0100;
            default: row[COEF_W*k +: COEF_W] = 16'hFF00;
          endcase
        end
        default: row[COEF_W*k +: COEF_W] = 16'h001C;   // about 1/9
      endcase
    end
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus: directed frames, random frames of small size, then one full
  // frame at maximum height and one at maximum width.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [SAMPLE_W-1:0] sat_frame [9] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255,
                                           8'd255, 8'd0, 8'd255, 8'd0};
    logic [SAMPLE_W-1:0] neg_frame [9] = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd201,
                                           8'd254, 8'd0, 8'd255, 8'd7};
    int unsigned w_val, h_val, fw, fh, n, kind, seg, random_items, i;
    bit          restart;

    // all inputs known from time zero
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.gray_sample = '0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_IMAGE_WIDTH;
    cfg_ch.wdata     = '0;

    // shadow state after reset
    width_reg    = SIZE_W'(SIZE_RST);
    height_reg   = SIZE_W'(SIZE_RST);
    coef_rows[0] = COEF_OUTER_RST;
    coef_rows[1] = COEF_INNER_RST;
    coef_rows[2] = COEF_OUTER_RST;
    for (i = 0; i < MAX_W; i++) begin
      older_line[i] = '0;
      newer_line[i] = '0;
    end
    for (i = 0; i < KSIZE * KSIZE; i++) win[i / KSIZE][i % KSIZE] = '0;
    row_pos = 0;
    col_pos = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: sender idles 18%, receiver 68% ---
    // undersized width/height clamp to 3; all-max kernel saturates at 255
    write_cfg(REG_IMAGE_WIDTH, 48'd0);
    write_cfg(REG_IMAGE_HEIGHT, 48'd2);
    write_cfg(REG_COEF_TOP, 48'h7FFF_7FFF_7FFF);
    write_cfg(REG_COEF_MIDDLE, 48'h7FFF_7FFF_7FFF);
    write_cfg(REG_COEF_BOTTOM, 48'h7FFF_7FFF_7FFF);
    for (i = 0; i < 9; i++) samples_to_send.push_back(sat_frame[i]);
    drain_results();

    // centre weight -0.5: negative sum, abs, fraction truncated (201 -> 100)
    write_cfg(REG_COEF_TOP, 48'h0);
    write_cfg(REG_COEF_MIDDLE, 48'h0000_FF80_0000);
    write_cfg(REG_COEF_BOTTOM, 48'h0);
    for (i = 0; i < 9; i++) samples_to_send.push_back(neg_frame[i]);
    drain_results();

    // partial frame, then the first random segment rewrites the size mid-frame
    write_cfg(REG_IMAGE_WIDTH, 48'd5);
    write_cfg(REG_IMAGE_HEIGHT, 48'd3);
    for (i = 0; i < 7; i++) samples_to_send.push_back(random_gray());
    drain_results();

    // --- random frames; idling swaps halfway ---
    seg = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (random_items >= RANDOM_ITEMS / 2) begin
        send_idle_pct = 68;
        recv_idle_pct = 18;
      end
      restart = (seg == 0) || ($urandom_range(3) != 0);
      if (restart) begin
        case ($urandom_range(9))
          0:       w_val = $urandom_range(2);
          1:       w_val = $urandom_range(40, 13);
          default: w_val = $urandom_range(12, 3);
        endcase
        h_val = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(8, 3);
        if (w_val > 12 && h_val > 4) h_val = 4;
        write_cfg(REG_IMAGE_WIDTH, COEF_ROW_W'(w_val));
        write_cfg(REG_IMAGE_HEIGHT, COEF_ROW_W'(h_val));
      end
      kind = $urandom_range(3);
      write_cfg(REG_COEF_TOP, random_coef_row(kind));
      write_cfg(REG_COEF_MIDDLE, random_coef_row(kind));
      write_cfg(REG_COEF_BOTTOM, random_coef_row(kind));

      // mostly a frame and a bit of the next; sometimes a fragment
      fw = (width_reg < 3) ? 3 : width_reg;
      fh = (height_reg < 3) ? 3 : height_reg;
      if ($urandom_range(4) == 0) n = $urandom_range(fw * fh, 1);
      else n = fw * fh + $urandom_range(fw);
      for (i = 0; i < n; i++) samples_to_send.push_back(random_gray());
      random_items += n;
      drain_results();
      seg++;
    end

    // --- full-size frames with no idling ---
    send_idle_pct = 0;
    recv_idle_pct = 0;

    // tallest frame (oversized height clamps to 1024), Gaussian kernel
    write_cfg(REG_IMAGE_WIDTH, 48'd3);
    write_cfg(REG_IMAGE_HEIGHT, 48'd2000);
    write_cfg(REG_COEF_TOP, COEF_OUTER_RST);
    write_cfg(REG_COEF_MIDDLE, COEF_INNER_RST);
    write_cfg(REG_COEF_BOTTOM, COEF_OUTER_RST);
    for (i = 0; i < 3 * MAX_H; i++) samples_to_send.push_back(random_gray());
    drain_results();

    // widest frame (all-ones width clamps to 1024); receiver stalls in row 1
    write_cfg(REG_IMAGE_WIDTH, 48'h7FF);
    write_cfg(REG_IMAGE_HEIGHT, 48'd3);
    write_cfg(REG_COEF_TOP, random_coef_row(1));
    write_cfg(REG_COEF_MIDDLE, random_coef_row(1));
    write_cfg(REG_COEF_BOTTOM, random_coef_row(1));
    pressure_start = samples_accepted + MAX_W + 200;
    for (i = 0; i < 3 * MAX_W; i++) samples_to_send.push_back(random_gray());
    drain_results();

    $display("Streamed %0d samples, checked %0d results, %0d register writes.",
             samples_accepted, results_checked, reg_writes);
    $display("Frames from 3x3 to 1024 wide and 1024 tall, signed and saturating kernels.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard limit in case the block hangs or drops results
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("Timeout: %0d results still pending", expected_pixels.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

### filelist.f
rtl/core/c3ac_pkg.sv
rtl/core/c3ac_in_if.sv
rtl/core/c3ac_out_if.sv
rtl/core/c3ac_cfg_if.sv
rtl/core/c3ac_ram.sv
rtl/core/c3ac_outq.sv
rtl/core/convolution_3x3_abs_clamp_top.sv
test/testbench.sv
